### hw/rtl/convex_hull_min_line_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the convex hull minimum line engine
// Implication checks sampled on the rising edge of clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef CONVEX_HULL_MIN_LINE_ENGINE_CORE_ASSERT_SVH
`define CONVEX_HULL_MIN_LINE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication
`define CHMLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define CHMLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/chmle_pkg.sv
// ---------------------------------------------------------------------------
// chmle_pkg
// Shared types and constants of the convex hull minimum line engine.
// ---------------------------------------------------------------------------
package chmle_pkg;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int X_W     = 32;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 11;

  // at most this many lines in the range end the ternary search
  localparam int SCAN_LIMIT = 5;
  // removal test needs this many lines
  localparam int REMOVE_MIN = 3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // one hull entry
  typedef struct packed {
    logic [ICPT_W-1:0]  icpt;
    logic [SLOPE_W-1:0] slope;
  } line_t;

  // removal test result
  typedef struct packed {
    logic done;
    logic useless;
  } cmp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD1,
    ST_A_RD2,
    ST_A_CAP,
    ST_A_CMP,
    ST_A_WR,
    ST_Q_CHK,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_WAIT,
    ST_Q_SCAN,
    ST_Q_SWAIT
  } state_t;

endpackage

### hw/rtl/convex_hull_min_line_engine_core.sv
// ---------------------------------------------------------------------------
// convex_hull_min_line_engine_core
// Convex hull trick engine: stack hull of lines, minimum queries at a point.
// ---------------------------------------------------------------------------
// One transaction is processed at a time, each giving exactly one result.
// An add runs removal tests while the hull holds enough lines, each test
// made of two reads of the line store, a capture state and the exact
// compare, then writes the line; a rejected add or a query on an empty
// hull is answered straight from idle. A query runs ternary steps (a split
// check, two reads and a wait on the evaluator), then a last check and the
// final scan. The line store has no reset and needs no clearing pass: only
// entries below the hull size are read.
module convex_hull_min_line_engine_core #(
  parameter int MAX_LINES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: slope[31:0], intercept[79:32], x_point[111:80]
  input  logic [111:0] in_tdata,
  // in_tuser: op
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: min_value[63:0], line_count[74:64], zero fill to 80 bits
  output logic [79:0]  out_tdata,
  // out_tuser: status
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  // divide by three through a reciprocal, exact for sums below 2**(AW+2)
  localparam int K  = AW + 3;
  localparam logic [K-1:0] RECIP = K'(((2 ** K) + 2) / 3);

  chmle_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     size_r, size_nxt;
  chmle_pkg::line_t  l1_r, l1_nxt, l3_r, l3_nxt;
  logic signed [chmle_pkg::X_W-1:0]   x_r, x_nxt;
  logic [AW-1:0]     low_r, low_nxt, high_r, high_nxt;
  logic [AW-1:0]     m1_r, m1_nxt, m2_r, m2_nxt, idx_r, idx_nxt;
  logic [2:0]        rem_r, rem_nxt;
  logic              got1_r, got1_nxt, first_r, first_nxt;
  logic              is_query_r, is_query_nxt, rd_valid_r;
  logic signed [chmle_pkg::VAL_W-1:0] v1_r, v1_nxt, best_r, best_nxt, cand;
  logic              out_valid_r, out_valid_nxt;
  logic [chmle_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [chmle_pkg::CNT_W-1:0] out_count_r, out_count_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  chmle_pkg::line_t  mem_rdata, in_line;
  chmle_pkg::cmp_stat_t cmp_stat;
  logic              cmp_start, ev_valid;
  logic signed [chmle_pkg::VAL_W-1:0] ev_value;
  logic [AW-1:0]     span;
  logic [AW+1:0]     n1, n2;
  logic [AW+1+K:0]   p1, p2;
  logic              in_acc;

  assign in_line.slope = in_tdata[31:0];
  assign in_line.icpt  = in_tdata[79:32];
  assign in_acc        = in_tvalid && in_tready;

  chmle_line_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (l3_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  chmle_line_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rd_valid_r && is_query_r),
    .line_in (mem_rdata),
    .x_in    (x_r),
    .valid   (ev_valid),
    .value   (ev_value)
  );

  chmle_cross_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .l1    (l1_r),
    .l2    (mem_rdata),
    .l3    (l3_r),
    .stat  (cmp_stat)
  );

  // ternary split points and the running-minimum candidate
  always_comb begin
    span = high_r - low_r;
    n1   = (AW+2)'(low_r) + (AW+2)'(low_r) + (AW+2)'(high_r);
    n2   = (AW+2)'(low_r) + (AW+2)'(high_r) + (AW+2)'(high_r);
    p1   = (AW+2+K)'(n1) * (AW+2+K)'(RECIP);
    p2   = (AW+2+K)'(n2) * (AW+2+K)'(RECIP);
    cand = (first_r || ev_value < best_r) ? ev_value : best_r;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    l1_nxt         = l1_r;
    l3_nxt         = l3_r;
    x_nxt          = x_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    m1_nxt         = m1_r;
    m2_nxt         = m2_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    got1_nxt       = got1_r;
    first_nxt      = first_r;
    is_query_nxt   = is_query_r;
    v1_nxt         = v1_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(size_r - CW'(1));
    mem_re         = 1'b0;
    mem_raddr      = '0;
    cmp_start      = 1'b0;
    in_tready      = (state_r == chmle_pkg::ST_IDLE) && !out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      chmle_pkg::ST_IDLE: begin
        if (in_acc) begin
          is_query_nxt = in_tuser;
          x_nxt        = $signed(in_tdata[111:80]);
          l3_nxt       = in_line;
          if (in_tuser == chmle_pkg::OP_ADD) begin
            if (size_r == CW'(MAX_LINES)) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = chmle_pkg::STATUS_FULL;
              out_count_nxt  = chmle_pkg::CNT_W'(size_r);
            end else begin
              size_nxt = size_r + CW'(1);
              if (32'(size_r) + 1 >= chmle_pkg::REMOVE_MIN) begin
                state_nxt = chmle_pkg::ST_A_RD1;
              end else begin
                state_nxt = chmle_pkg::ST_A_WR;
              end
            end
          end else if (size_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = chmle_pkg::STATUS_EMPTY;
            out_count_nxt  = chmle_pkg::CNT_W'(size_r);
          end else begin
            low_nxt   = '0;
            high_nxt  = AW'(size_r - CW'(1));
            state_nxt = chmle_pkg::ST_Q_CHK;
          end
        end
      end
      chmle_pkg::ST_A_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(size_r - CW'(3));
        state_nxt = chmle_pkg::ST_A_RD2;
      end
      chmle_pkg::ST_A_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(size_r - CW'(2));
        l1_nxt    = mem_rdata;
        state_nxt = chmle_pkg::ST_A_CAP;
      end
      chmle_pkg::ST_A_CAP: begin
        cmp_start = 1'b1;
        state_nxt = chmle_pkg::ST_A_CMP;
      end
      chmle_pkg::ST_A_CMP: begin
        if (cmp_stat.done) begin
          if (cmp_stat.useless) begin
            // middle line drops out, the newest takes its place
            size_nxt = size_r - CW'(1);
            if (32'(size_r) - 1 >= chmle_pkg::REMOVE_MIN) begin
              state_nxt = chmle_pkg::ST_A_RD1;
            end else begin
              state_nxt = chmle_pkg::ST_A_WR;
            end
          end else begin
            state_nxt = chmle_pkg::ST_A_WR;
          end
        end
      end
      chmle_pkg::ST_A_WR: begin
        mem_we         = 1'b1;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = chmle_pkg::STATUS_OK;
        out_count_nxt  = chmle_pkg::CNT_W'(size_r);
        state_nxt      = chmle_pkg::ST_IDLE;
      end
      chmle_pkg::ST_Q_CHK: begin
        got1_nxt = 1'b0;
        if (32'(span) >= chmle_pkg::SCAN_LIMIT) begin
          m1_nxt    = p1[K+AW-1:K];
          m2_nxt    = p2[K+AW-1:K];
          state_nxt = chmle_pkg::ST_Q_RD1;
        end else begin
          idx_nxt   = low_r;
          rem_nxt   = 3'(span) + 3'd1;
          first_nxt = 1'b1;
          state_nxt = chmle_pkg::ST_Q_SCAN;
        end
      end
      chmle_pkg::ST_Q_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = m1_r;
        state_nxt = chmle_pkg::ST_Q_RD2;
      end
      chmle_pkg::ST_Q_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = m2_r;
        state_nxt = chmle_pkg::ST_Q_WAIT;
      end
      chmle_pkg::ST_Q_WAIT: begin
        if (ev_valid) begin
          if (!got1_r) begin
            v1_nxt   = ev_value;
            got1_nxt = 1'b1;
          end else begin
            if (v1_r >= ev_value) begin
              low_nxt = m1_r + AW'(1);
            end else begin
              high_nxt = m2_r - AW'(1);
            end
            state_nxt = chmle_pkg::ST_Q_CHK;
          end
        end
      end
      chmle_pkg::ST_Q_SCAN, chmle_pkg::ST_Q_SWAIT: begin
        if (state_r == chmle_pkg::ST_Q_SCAN) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r;
          if (idx_r == high_r) begin
            state_nxt = chmle_pkg::ST_Q_SWAIT;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        // running minimum over the scanned lines
        if (ev_valid) begin
          best_nxt  = cand;
          first_nxt = 1'b0;
          rem_nxt   = rem_r - 3'd1;
          if (rem_r == 3'd1) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = cand;
            out_status_nxt = chmle_pkg::STATUS_OK;
            out_count_nxt  = chmle_pkg::CNT_W'(size_r);
            state_nxt      = chmle_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = chmle_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chmle_pkg::ST_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
      is_query_r  <= 1'b0;
      got1_r      <= 1'b0;
      first_r     <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
      rd_valid_r  <= mem_re;
      is_query_r  <= is_query_nxt;
      got1_r      <= got1_nxt;
      first_r     <= first_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    l1_r         <= l1_nxt;
    l3_r         <= l3_nxt;
    x_r          <= x_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    m1_r         <= m1_nxt;
    m2_r         <= m2_nxt;
    idx_r        <= idx_nxt;
    v1_r         <= v1_nxt;
    best_r       <= best_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_count_r, out_value_r};

  `include "convex_hull_min_line_engine_core_assert.svh"

  `CHMLE_ASSERT_SAME(a_one_at_a_time, in_tready, !out_tvalid)
  `CHMLE_ASSERT_SAME(a_full_count, out_tvalid && out_tuser == chmle_pkg::STATUS_FULL,
                     out_tdata[74:64] == chmle_pkg::CNT_W'(MAX_LINES) && out_tdata[63:0] == '0)
  `CHMLE_ASSERT_SAME(a_empty_zero, out_tvalid && out_tuser == chmle_pkg::STATUS_EMPTY,
                     out_tdata[74:0] == '0)
  `CHMLE_ASSERT_NEXT(a_add_busy, in_tvalid && in_tready && in_tuser == chmle_pkg::OP_ADD,
                     !in_tready)

endmodule

### hw/rtl/chmle_line_mem.sv
// ---------------------------------------------------------------------------
// chmle_line_mem
// Hull line store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module chmle_line_mem #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  chmle_pkg::line_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output chmle_pkg::line_t rdata
);

  chmle_pkg::line_t mem [2**AW];
  chmle_pkg::line_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/chmle_line_eval.sv
// ---------------------------------------------------------------------------
// chmle_line_eval
// Two-stage evaluator of slope*x + intercept; one start per cycle.
// ---------------------------------------------------------------------------
module chmle_line_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  chmle_pkg::line_t                line_in,
  input  logic signed [chmle_pkg::X_W-1:0] x_in,
  output logic                            valid,
  output logic signed [chmle_pkg::VAL_W-1:0] value
);

  logic                                 v1_r, v2_r;
  logic signed [chmle_pkg::VAL_W-1:0]   prod_r;
  logic signed [chmle_pkg::ICPT_W-1:0]  icpt_r;
  logic signed [chmle_pkg::VAL_W-1:0]   value_r;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // multiply, then add
  always_ff @(posedge clk) begin
    prod_r  <= $signed(line_in.slope) * x_in;
    icpt_r  <= $signed(line_in.icpt);
    value_r <= prod_r + chmle_pkg::VAL_W'(icpt_r);
  end

  assign valid = v2_r;
  assign value = value_r;

endmodule

### hw/rtl/chmle_cross_cmp.sv
// ---------------------------------------------------------------------------
// chmle_cross_cmp
// Exact removal test (b2-b1)*(m1-m3) <= (b3-b1)*(m1-m2) in registered steps:
// differences, low partial products, high partial products, sums, compare.
// ---------------------------------------------------------------------------
module chmle_cross_cmp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  chmle_pkg::line_t     l1,
  input  chmle_pkg::line_t     l2,
  input  chmle_pkg::line_t     l3,
  output chmle_pkg::cmp_stat_t stat
);

  localparam int DW = chmle_pkg::ICPT_W + 1;
  localparam int EW = chmle_pkg::SLOPE_W + 1;
  localparam int SW = DW + EW;

  logic       busy_r, done_r, useless_r;
  logic [1:0] ph_r;

  logic signed [DW-1:0]       d1_r, d2_r;
  logic signed [EW-1:0]       e_r, f_r;
  logic signed [32+EW:0]      lol_r, lor_r;
  logic signed [DW-32+EW-1:0] hil_r, hir_r;
  logic signed [SW-1:0]       sl_r, sr_r;

  // phase sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      d1_r <= DW'($signed(l2.icpt)) - DW'($signed(l1.icpt));
      d2_r <= DW'($signed(l3.icpt)) - DW'($signed(l1.icpt));
      e_r  <= EW'($signed(l1.slope)) - EW'($signed(l3.slope));
      f_r  <= EW'($signed(l1.slope)) - EW'($signed(l2.slope));
    end
    if (busy_r && ph_r == 2'd0) begin
      lol_r <= $signed({1'b0, d1_r[31:0]}) * e_r;
      lor_r <= $signed({1'b0, d2_r[31:0]}) * f_r;
    end
    if (busy_r && ph_r == 2'd1) begin
      hil_r <= $signed(d1_r[DW-1:32]) * e_r;
      hir_r <= $signed(d2_r[DW-1:32]) * f_r;
    end
    if (busy_r && ph_r == 2'd2) begin
      sl_r <= SW'(lol_r) + (SW'(hil_r) <<< 32);
      sr_r <= SW'(lor_r) + (SW'(hir_r) <<< 32);
    end
    if (busy_r && ph_r == 2'd3) begin
      useless_r <= (sl_r <= sr_r);
    end
  end

  assign stat.done    = done_r;
  assign stat.useless = useless_r;

endmodule

### tb/convex_hull_min_line_engine_core_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// convex_hull_min_line_engine_core_checker
// Watches both stream channels of the hull engine. Every accepted input
// transaction is run through a local hull model and its expected result is
// queued; every accepted output transaction is compared against the oldest.
// ---------------------------------------------------------------------------
module convex_hull_min_line_engine_core_checker
  import chmle_pkg::*;
#(
  parameter int MAX_LINES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [111:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [VAL_W-1:0] min_value;
    logic [1:0]       status;
    logic [CNT_W-1:0] line_count;
  } hull_result_t;

  hull_result_t result_q[$];

  // model hull
  logic signed [SLOPE_W-1:0] line_slope[MAX_LINES];
  logic signed [ICPT_W-1:0]  line_icpt[MAX_LINES];
  int unsigned               line_total;

  // exact test: is the middle of three lines never the minimum
  function automatic bit middle_redundant(int unsigned i1, int unsigned i2, int unsigned i3);
    longint b1, b2, b3, m1, m2, m3;
    logic signed [127:0] db2, db3, dm3, dm2, lhs, rhs;
    b1 = line_icpt[i1];
    b2 = line_icpt[i2];
    b3 = line_icpt[i3];
    m1 = line_slope[i1];
    m2 = line_slope[i2];
    m3 = line_slope[i3];
    db2 = b2 - b1;
    db3 = b3 - b1;
    dm3 = m1 - m3;
    dm2 = m1 - m2;
    lhs = db2 * dm3;
    rhs = db3 * dm2;
    return lhs <= rhs;
  endfunction

  function automatic longint value_at(int unsigned idx, longint xv);
    longint m, b;
    m = line_slope[idx];
    b = line_icpt[idx];
    return m * xv + b;
  endfunction

  // apply one input transaction to the model hull
  function automatic hull_result_t hull_update(logic op, logic [111:0] data);
    hull_result_t r;
    int unsigned lo, hi, m1, m2;
    longint xv, best, v;
    r.min_value = '0;
    r.status    = STATUS_OK;
    if (op == OP_ADD) begin
      if (line_total >= MAX_LINES) begin
        r.status = STATUS_FULL;
      end else begin
        line_slope[line_total] = data[31:0];
        line_icpt[line_total]  = data[79:32];
        line_total++;
        while (line_total >= REMOVE_MIN &&
               middle_redundant(line_total - 3, line_total - 2, line_total - 1)) begin
          line_slope[line_total - 2] = line_slope[line_total - 1];
          line_icpt[line_total - 2]  = line_icpt[line_total - 1];
          line_total--;
        end
      end
    end else if (line_total == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      xv = $signed(data[111:80]);
      lo = 0;
      hi = line_total - 1;
      // ternary narrowing, then a linear scan of the remainder
      while (hi - lo >= SCAN_LIMIT) begin
        m1 = (lo + lo + hi) / 3;
        m2 = (lo + hi + hi) / 3;
        if (value_at(m1, xv) >= value_at(m2, xv)) lo = m1 + 1;
        else hi = m2 - 1;
      end
      best = value_at(lo, xv);
      for (int unsigned i = lo + 1; i <= hi; i++) begin
        v = value_at(i, xv);
        if (v < best) best = v;
      end
      r.min_value = best;
    end
    r.line_count = line_total[CNT_W-1:0];
    return r;
  endfunction

  assign pending = result_q.size();

  initial begin
    fail_count = 0;
    line_total = 0;
  end

  always @(posedge clk) begin
    hull_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) result_q = {result_q, hull_update(in_tuser, in_tdata)};
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected output transaction: tdata %h tuser %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_tdata[63:0] !== exp_r.min_value) begin
            $error("min_value: expected %0d actual %0d",
                   $signed(exp_r.min_value), $signed(out_tdata[63:0]));
            fail_count++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[74:64] !== exp_r.line_count) begin
            $error("line_count: expected %0d actual %0d", exp_r.line_count, out_tdata[74:64]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/convex_hull_min_line_engine_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// convex_hull_min_line_engine_core_test
// Stimulus and verdict for the hull engine: directed extremes, a random mix
// of adds and queries, then a fill of the hull past its capacity with
// queries along the way. Both channels stall at random.
// ---------------------------------------------------------------------------
module convex_hull_min_line_engine_core_test;
  import chmle_pkg::*;

  localparam int MAX_LINES   = 1024;
  localparam int CYCLE_LIMIT = 1000000;

  logic         clk;
  logic         rst_n;
  logic [111:0] in_tdata;
  logic         in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  int           fail_count;
  int           pending;
  int           cycle_count;
  bit           steady;
  logic signed [31:0] run_slope;

  convex_hull_min_line_engine_core #(.MAX_LINES(MAX_LINES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  convex_hull_min_line_engine_core_checker #(.MAX_LINES(MAX_LINES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one input transaction, with random gaps ahead of it
  task automatic send_item(logic op, logic [31:0] slope, logic [47:0] icpt, logic [31:0] xp);
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {xp, icpt, slope};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic add_line(logic [31:0] slope, logic [47:0] icpt);
    send_item(OP_ADD, slope, icpt, $urandom());
  endtask

  task automatic query_at(logic [31:0] xp);
    send_item(OP_QUERY, $urandom(), 48'({$urandom(), $urandom()}), xp);
  endtask

  function automatic logic [31:0] pick_x();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    longint t;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_ADD;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cycle_count = 0;
    steady      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty hull, field extremes, equal slopes
    query_at(32'd0);
    query_at(32'h7fff_ffff);
    add_line(32'h7fff_ffff, 48'h7fff_ffff_ffff);
    query_at(32'h8000_0000);
    query_at(32'h7fff_ffff);
    add_line(32'd0, 48'h8000_0000_0000);
    add_line(32'h8000_0000, 48'd0);
    query_at(32'h8000_0000);
    query_at(32'h7fff_ffff);
    query_at(32'd0);
    add_line(32'h8000_0000, 48'h8000_0000_0000);
    add_line(32'h8000_0000, 48'h7fff_ffff_ffff);
    add_line(32'h7fff_ffff, 48'h8000_0000_0000);
    query_at(32'hffff_ffff);
    add_line(32'h0000_0001, 48'hffff_ffff_ffff);
    add_line(32'hffff_ffff, 48'h0000_0000_0001);
    query_at(32'h0000_0001);
    query_at(32'h8000_0001);
    query_at(32'hffff_ffff);

    // random mix: mostly decreasing slopes, some out-of-order noise
    run_slope = 32'h7fff_ffff;
    for (int i = 0; i < 70; i++) begin
      if ($urandom_range(99) < 55) begin
        run_slope = run_slope - $urandom_range(1 << 22, 1);
        if ($urandom_range(9) == 0) add_line($urandom(), 48'({$urandom(), $urandom()}));
        else add_line(run_slope, 48'({$urandom(), $urandom()}));
      end else begin
        query_at(pick_x());
      end
    end

    // fill past capacity: lowest slopes, intercepts falling off a concave
    // curve from the top, so every one of these lines stays on the hull
    for (int i = 0; i < 1060; i++) begin
      steady = (i >= 200 && i < 550);
      t = i;
      add_line(32'(-2 * t - 2147480000), 48'h7fff_ffff_ffff - 48'(t * t * 3));
      if (i % 12 == 0) query_at(pick_x());
    end
    steady = 1'b0;
    for (int i = 0; i < 12; i++) query_at(pick_x());
    in_tvalid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/chmle_pkg.sv
hw/rtl/chmle_line_mem.sv
hw/rtl/chmle_line_eval.sv
hw/rtl/chmle_cross_cmp.sv
hw/rtl/convex_hull_min_line_engine_core.sv
tb/convex_hull_min_line_engine_core_checker.sv
tb/convex_hull_min_line_engine_core_test.sv
